[hw/rtl/mti_pkg.sv]
package mti_pkg;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_PTS    = 8;
  localparam int GRID_DEPTH  = NUM_AXES * AXIS_PTS;
  localparam int TABLE_DEPTH = 512;
  localparam int VAL_W       = 32;

  typedef enum logic [1:0] {
    CMD_GRID  = 2'd0,
    CMD_TABLE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EQUAL = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_DIMS = 2'd0,
    CFG_LEN0 = 2'd1,
    CFG_LEN1 = 2'd2,
    CFG_LEN2 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         axis_sel;
    logic [8:0]         slot;
    logic signed [31:0] load_data;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

[hw/rtl/multilinear_table_interpolator_unit.sv]
// Loads (grid point, table word) write on acceptance; no result is produced.
// A query runs a range check on each axis, a bracketing search on each axis,
// corner reads from the table and then linear steps, each a shift-add
// multiply followed by a restoring divide.
// One item is worked on at a time; the result register frees the output side.
// Synchronous reset resets control and configuration; memories are not cleared.
module multilinear_table_interpolator_unit
  import mti_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [4:0] {
    S_IDLE, S_TAB0, S_TAB1, S_RNG0, S_RNG1, S_RNG2,
    S_BR0, S_BR1, S_BR2, S_BR3, S_BR4, S_BR5, S_BR6,
    S_CA, S_CB, S_LA, S_LB, S_LC, S_MUL, S_DIV, S_WB, S_DONE
  } state_t;

  state_t state;

  logic [1:0] dims;
  logic [3:0] axis_len [NUM_AXES];
  logic [2:0] eff_last [NUM_AXES];

  logic signed [31:0] grid_mem [GRID_DEPTH];
  logic signed [31:0] tab_mem  [TABLE_DEPTH];
  logic signed [63:0] val_mem  [8];

  logic [4:0] g_raddr;
  logic [8:0] t_raddr;
  logic [2:0] v_raddr;
  logic signed [31:0] g_rdata, t_rdata;
  logic signed [63:0] v_rdata;
  logic       v_we;
  logic [2:0] v_waddr;
  logic signed [63:0] v_wdata;

  logic signed [31:0] coord [NUM_AXES];
  logic signed [31:0] x0 [NUM_AXES];
  logic signed [31:0] x1 [NUM_AXES];
  logic [2:0] lo [NUM_AXES];
  logic [1:0] ax;
  logic [2:0] j, hi, lm;
  logic [3:0] cm;
  logic signed [31:0] g0, x1_q;
  status_t status;
  logic signed [63:0] f0, res;
  logic [96:0] mcand, prod;
  logic [32:0] mplier, dxm, rem;
  logic [63:0] quo;
  logic [6:0] cnt;
  logic neg, zero;

  function automatic logic [2:0] clamp_last(input logic [3:0] n);
    logic [3:0] e;
    e = (n < 4'd2) ? 4'd2 : ((n > 4'(AXIS_PTS)) ? 4'(AXIS_PTS) : n);
    return 3'(e - 4'd1);
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) eff_last[k] = clamp_last(axis_len[k]);
  end

  logic [2:0] last;
  assign last = eff_last[ax];

  // corner address, axis 0 fastest
  logic [2:0] ci [NUM_AXES];
  logic [8:0] caddr;
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++)
      ci[k] = (2'(k) < dims) ? 3'(lo[k] + {2'b0, cm[k]}) : 3'd0;
    caddr = 9'(ci[0]) + 9'((9'(eff_last[0]) + 9'd1) *
            (9'(ci[1]) + 9'((9'(eff_last[1]) + 9'd1) * 9'(ci[2]))));
  end

  always_comb begin
    case (state)
      S_RNG0:  g_raddr = {ax, 3'd0};
      S_RNG1:  g_raddr = {ax, last};
      S_BR0:   g_raddr = {ax, last};
      S_BR2:   g_raddr = {ax, j};
      S_BR4:   g_raddr = {ax, hi};
      S_BR5:   g_raddr = {ax, 3'(hi - 3'd1)};
      default: g_raddr = '0;
    endcase
  end

  assign t_raddr = (state == S_CA) ? caddr : '0;
  assign v_raddr = (state == S_LA) ? {lm[1:0], 1'b0} : {lm[1:0], 1'b1};

  // linear step setup
  logic signed [32:0] d_s, dx_s;
  logic signed [63:0] df_s;
  always_comb begin
    d_s  = {coord[ax][31], coord[ax]} - {x0[ax][31], x0[ax]};
    dx_s = {x1[ax][31], x1[ax]} - {x0[ax][31], x0[ax]};
    df_s = v_rdata - f0;
  end

  logic [33:0] r_sh;
  assign r_sh = {rem, prod[96]};

  logic signed [63:0] step_res;
  assign step_res = zero ? f0 : (neg ? f0 - $signed(quo) : f0 + $signed(quo));

  logic [3:0] pairs;
  assign pairs = 4'd1 << (dims - 2'd1 - ax);

  assign v_we    = (state == S_CB) || (state == S_WB);
  assign v_waddr = (state == S_CB) ? cm[2:0] : lm;
  assign v_wdata = (state == S_CB) ? 64'(t_rdata) : step_res;

  always_ff @(posedge clk) begin
    g_rdata <= grid_mem[g_raddr];
    t_rdata <= tab_mem[t_raddr];
    v_rdata <= val_mem[v_raddr];
    if (in_valid && in_ready && in_item.command == CMD_GRID &&
        in_item.axis_sel < 2'(NUM_AXES) && in_item.slot < 9'(AXIS_PTS))
      grid_mem[{in_item.axis_sel, in_item.slot[2:0]}] <= in_item.load_data;
    if (in_valid && in_ready && in_item.command == CMD_TABLE)
      tab_mem[in_item.slot] <= in_item.load_data;
    if (v_we) val_mem[v_waddr] <= v_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= '0;
      for (int k = 0; k < NUM_AXES; k++) axis_len[k] <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIMS: dims        <= cfg_data[1:0];
        CFG_LEN0: axis_len[0] <= cfg_data;
        CFG_LEN1: axis_len[1] <= cfg_data;
        CFG_LEN2: axis_len[2] <= cfg_data;
        default:  dims        <= dims;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_item.command == CMD_QUERY) begin
            coord[0] <= in_item.coord_0;
            coord[1] <= in_item.coord_1;
            coord[2] <= in_item.coord_2;
            status   <= ST_OK;
            ax       <= '0;
            state    <= (dims == 2'd0) ? S_TAB0 : S_RNG0;
          end
        end
        S_TAB0: state <= S_TAB1;
        S_TAB1: begin
          res   <= 64'(t_rdata);
          state <= S_DONE;
        end
        S_RNG0: state <= S_RNG1;
        S_RNG1: begin
          g0    <= g_rdata;
          state <= S_RNG2;
        end
        S_RNG2: begin
          if (coord[ax] < g0 || coord[ax] > g_rdata) begin
            status <= ST_RANGE;
            state  <= S_DONE;
          end else if (ax == dims - 2'd1) begin
            ax    <= '0;
            state <= S_BR0;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_RNG0;
          end
        end
        S_BR0: state <= S_BR1;
        S_BR1: begin
          if (g_rdata == coord[ax]) begin
            hi    <= last;
            state <= S_BR4;
          end else begin
            j     <= 3'd1;
            state <= S_BR2;
          end
        end
        S_BR2: state <= S_BR3;
        S_BR3: begin
          if (g_rdata > coord[ax] || j == last) begin
            hi    <= j;
            state <= S_BR4;
          end else begin
            j     <= j + 3'd1;
            state <= S_BR2;
          end
        end
        S_BR4: state <= S_BR5;
        S_BR5: begin
          x1_q  <= g_rdata;
          state <= S_BR6;
        end
        S_BR6: begin
          if (x1_q == g_rdata) begin
            status <= ST_EQUAL;
            state  <= S_DONE;
          end else begin
            lo[ax] <= hi - 3'd1;
            x0[ax] <= g_rdata;
            x1[ax] <= x1_q;
            if (ax == dims - 2'd1) begin
              cm    <= '0;
              state <= S_CA;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_BR0;
            end
          end
        end
        S_CA: state <= S_CB;
        S_CB: begin
          cm <= cm + 4'd1;
          if (cm + 4'd1 == (4'd1 << dims)) begin
            ax    <= '0;
            lm    <= '0;
            state <= S_LA;
          end else begin
            state <= S_CA;
          end
        end
        S_LA: state <= S_LB;
        S_LB: begin
          f0    <= v_rdata;
          state <= S_LC;
        end
        S_LC: begin
          neg    <= d_s[32] ^ df_s[63] ^ dx_s[32];
          zero   <= (d_s == '0) || (df_s == '0);
          mcand  <= {33'b0, (df_s[63] ? 64'(-df_s) : 64'(df_s))};
          mplier <= d_s[32] ? 33'(-d_s) : 33'(d_s);
          dxm    <= dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
          prod   <= '0;
          cnt    <= 7'd32;
          state  <= S_MUL;
        end
        S_MUL: begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == '0) begin
            rem   <= '0;
            quo   <= '0;
            cnt   <= 7'd96;
            state <= S_DIV;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end
        S_DIV: begin
          prod <= prod << 1;
          if (r_sh >= {1'b0, dxm}) begin
            rem <= 33'(r_sh - {1'b0, dxm});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= r_sh[32:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == '0) state <= S_WB;
        end
        S_WB: begin
          if ({1'b0, lm} + 4'd1 == pairs) begin
            lm <= '0;
            if (ax == dims - 2'd1) begin
              res   <= step_res;
              state <= S_DONE;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_LA;
            end
          end else begin
            lm    <= lm + 3'd1;
            state <= S_LA;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_item.interp_value <= (status == ST_OK) ? res[31:0] : 32'sd0;
            out_item.status       <= status;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dxm) else $error("remainder not below divisor");
  a_dx_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> dxm != '0) else $error("zero-width interval in step");
  a_axis_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RNG0 || state == S_BR0 || state == S_LA) |-> ax < dims)
    else $error("axis beyond dimensions in use");
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_valid |=> out_valid) else $error("result not posted");
`endif

endmodule
